// ===== rtl/sphc_pkg.sv =====
// ----------------------------------------------------------------------------
// sphc_pkg: shared types and constants of the split payload header checker
// Beat structs of both channels, header layout offsets and check limits.
// ----------------------------------------------------------------------------
`default_nettype none

package sphc_pkg;

    // Input beat: one header byte
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } sphc_in_t;

    // Result beat: status and decoded fields
    typedef struct packed {
        logic        valid_header;
        logic        rope_mode;
        logic [7:0]  row_total;
        logic [16:0] width_first;
        logic [16:0] width_second;
        logic [16:0] width_third;
        logic [63:0] module_size;
    } sphc_out_t;

    // Handshake control from the top level to the parse stage
    typedef struct packed {
        logic go;    // held byte is consumed this cycle
        logic last;  // ... and it closes the payload
    } sphc_step_t;

    // Byte offsets of the header regions
    localparam logic [7:0] MAGIC_END     = 8'd8;
    localparam logic [7:0] WORDS_END     = 8'd40;
    localparam logic [7:0] DIGEST_END    = 8'd72;
    localparam logic [7:0] PAYLOAD_BYTES = 8'd128;
    localparam logic [7:0] LAST_POS      = 8'd127;
    localparam logic [7:0] POS_MAX       = 8'd255;

    // Word indexes (byte offset / 4) inside the word region
    localparam logic [3:0] WORD_VERSION = 4'd2;
    localparam logic [3:0] WORD_LENGTH  = 4'd3;
    localparam logic [3:0] WORD_ROWS    = 4'd4;
    localparam logic [3:0] WORD_WIDTH0  = 4'd5;
    localparam logic [3:0] WORD_WIDTH1  = 4'd6;
    localparam logic [3:0] WORD_WIDTH2  = 4'd7;
    localparam logic [3:0] WORD_MSIZE_L = 4'd8;
    localparam logic [3:0] WORD_MSIZE_H = 4'd9;

    // Check limits
    localparam logic [31:0] HDR_VERSION      = 32'd1;
    localparam logic [31:0] HDR_LENGTH       = 32'd120;
    localparam logic [31:0] MAX_ROWS         = 32'd128;
    localparam logic [31:0] MAX_WIDTH        = 32'd65536;
    localparam logic [17:0] MAX_WIDTH_SUM    = 18'd65536;
    localparam logic [7:0]  ROPE_ROWS        = 8'd50;
    localparam logic [16:0] ROPE_WIDTH_FIRST = 17'd2048;
    localparam logic [16:0] ROPE_WIDTH_OTHER = 17'd256;

    // "AIPSP1\0\0" and "AIQRP1\0\0"
    localparam logic [7:0] PLAIN_MAGIC [8] =
        '{8'h41, 8'h49, 8'h50, 8'h53, 8'h50, 8'h31, 8'h00, 8'h00};
    localparam logic [7:0] ROPE_MAGIC [8] =
        '{8'h41, 8'h49, 8'h51, 8'h52, 8'h50, 8'h31, 8'h00, 8'h00};

endpackage

`default_nettype wire

// ===== rtl/sphc_in_stage.sv =====
// ----------------------------------------------------------------------------
// sphc_in_stage: input beat register
// Captures one byte beat; frees as soon as the parse stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_in_stage
    import sphc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sphc_in_t s_data,
    input  wire logic     advance,
    output logic          hold_valid,
    output sphc_in_t      hold_data
);

    logic     vld_reg;
    logic     vld_next;
    sphc_in_t data_reg;

    assign s_ready    = !vld_reg || advance;
    assign vld_next   = s_ready ? s_valid : vld_reg;
    assign hold_valid = vld_reg;
    assign hold_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sphc_parse.sv =====
// ----------------------------------------------------------------------------
// sphc_parse: header field assembly and checks
// Tracks the byte offset, assembles little-endian words and folds each check
// into sticky flags; forms the result for the closing byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_parse
    import sphc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire sphc_step_t step,
    input  wire sphc_in_t   beat,
    output sphc_out_t       result
);

    logic [7:0]  pos_reg,    pos_next;
    logic        plain_reg,  plain_next;
    logic        rope_reg,   rope_next;
    logic [23:0] asm_reg,    asm_next;
    logic        fail_reg,   fail_next;
    logic [7:0]  rows_reg,   rows_next;
    logic [16:0] width_reg  [3];
    logic [16:0] width_next [3];
    logic [17:0] sum_reg,    sum_next;
    logic [63:0] msize_reg,  msize_next;
    logic        digest_reg, digest_next;

    logic [7:0]  b;
    logic [31:0] word;
    logic [3:0]  widx;
    logic        width_bad;
    logic        ok;
    logic        rope_fit;

    assign b    = beat.payload_byte;
    assign word = {b, asm_reg};
    assign widx = pos_reg[5:2];

    // bad width: zero, not a multiple of 8, or alone beyond the sum limit
    assign width_bad = (word == 32'd0) || (word[2:0] != 3'd0) || (word > MAX_WIDTH);

    always_comb begin
        pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
        plain_next  = plain_reg;
        rope_next   = rope_reg;
        asm_next    = asm_reg;
        fail_next   = fail_reg;
        rows_next   = rows_reg;
        width_next  = width_reg;
        sum_next    = sum_reg;
        msize_next  = msize_reg;
        digest_next = digest_reg;

        if (pos_reg < MAGIC_END) begin
            plain_next = plain_reg && (b == PLAIN_MAGIC[pos_reg[2:0]]);
            rope_next  = rope_reg && (b == ROPE_MAGIC[pos_reg[2:0]]);
        end else if (pos_reg < WORDS_END) begin
            unique case (pos_reg[1:0])
                2'd0: asm_next = {16'd0, b};
                2'd1: asm_next[15:8] = b;
                2'd2: asm_next[23:16] = b;
                2'd3: begin
                    asm_next = '0;
                    unique case (widx)
                        WORD_VERSION: fail_next = fail_reg || (word != HDR_VERSION);
                        WORD_LENGTH:  fail_next = fail_reg || (word != HDR_LENGTH);
                        WORD_ROWS: begin
                            rows_next = word[7:0];
                            fail_next = fail_reg || (word == 32'd0) || (word > MAX_ROWS);
                        end
                        WORD_WIDTH0: begin
                            width_next[0] = word[16:0];
                            fail_next     = fail_reg || width_bad;
                            sum_next      = sum_reg + {1'b0, word[16:0]};
                        end
                        WORD_WIDTH1: begin
                            width_next[1] = word[16:0];
                            fail_next     = fail_reg || width_bad;
                            sum_next      = sum_reg + {1'b0, word[16:0]};
                        end
                        WORD_WIDTH2: begin
                            width_next[2] = word[16:0];
                            fail_next     = fail_reg || width_bad;
                            sum_next      = sum_reg + {1'b0, word[16:0]};
                        end
                        WORD_MSIZE_L: msize_next[31:0]  = word;
                        WORD_MSIZE_H: msize_next[63:32] = word;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end else if (pos_reg < DIGEST_END) begin
            digest_next = digest_reg || (b != 8'd0);
        end else if (pos_reg < PAYLOAD_BYTES) begin
            fail_next = fail_reg || (b != 8'd0);
        end else begin
            fail_next = 1'b1;
        end
    end

    // final verdict on the state as it stands after this byte
    always_comb begin
        rope_fit = (rows_next == ROPE_ROWS) && (width_next[0] == ROPE_WIDTH_FIRST)
                && (width_next[1] == ROPE_WIDTH_OTHER)
                && (width_next[2] == ROPE_WIDTH_OTHER);
        ok = !fail_next && (pos_reg == LAST_POS) && (plain_next || rope_next)
          && (sum_next <= MAX_WIDTH_SUM) && (msize_next != 64'd0) && digest_next
          && (!rope_next || rope_fit);
        result = '0;
        if (ok) begin
            result.valid_header = 1'b1;
            result.rope_mode    = rope_next;
            result.row_total    = rows_next;
            result.width_first  = width_next[0];
            result.width_second = width_next[1];
            result.width_third  = width_next[2];
            result.module_size  = msize_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step.go && step.last)) begin
            pos_reg    <= '0;
            plain_reg  <= 1'b1;
            rope_reg   <= 1'b1;
            asm_reg    <= '0;
            fail_reg   <= 1'b0;
            rows_reg   <= '0;
            width_reg  <= '{default: '0};
            sum_reg    <= '0;
            msize_reg  <= '0;
            digest_reg <= 1'b0;
        end else if (step.go) begin
            pos_reg    <= pos_next;
            plain_reg  <= plain_next;
            rope_reg   <= rope_next;
            asm_reg    <= asm_next;
            fail_reg   <= fail_next;
            rows_reg   <= rows_next;
            width_reg  <= width_next;
            sum_reg    <= sum_next;
            msize_reg  <= msize_next;
            digest_reg <= digest_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sphc_out_stage.sv =====
// ----------------------------------------------------------------------------
// sphc_out_stage: result beat register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_out_stage
    import sphc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire sphc_out_t result,
    output logic           free,
    output logic           m_valid,
    input  wire logic      m_ready,
    output sphc_out_t      m_data
);

    logic      vld_reg;
    logic      vld_next;
    sphc_out_t data_reg;

    assign free     = !vld_reg || m_ready;
    assign vld_next = load || (vld_reg && !m_ready);
    assign m_valid  = vld_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/split_payload_header_checker.sv =====
// ----------------------------------------------------------------------------
// split_payload_header_checker: 128-byte payload header checker
// Checks magic, version, length, rows, widths, module size, digest and
// padding byte by byte; emits one status beat per payload.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  s_      | in        | s_valid / s_ready  | sphc_in_t  (one header byte)
//  m_      | out       | m_valid / m_ready  | sphc_out_t (status, on last byte)
//
//  One byte per cycle while no closing byte waits; m_valid is registered.
//  Input register -> parse logic and sticky flags -> result register.
//  Non-final bytes never wait on the result side; a closing byte waits only
//  while an earlier result is still held and not taken.
//  aresetn is synchronous; after reset the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module split_payload_header_checker
    import sphc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sphc_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output sphc_out_t      m_data
);

    logic       hold_valid;
    sphc_in_t   hold_data;
    logic       out_free;
    sphc_step_t step;
    sphc_out_t  result;

    assign step = '{go:   hold_valid && (!hold_data.last_byte || out_free),
                    last: hold_data.last_byte};

    sphc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (step.go),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    sphc_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (hold_data),
        .result  (result)
    );

    sphc_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step.go && step.last),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/sphc_checker.sv =====
// ----------------------------------------------------------------------------
// sphc_checker: port-level checks of the header checker
// Result beat stability and consistency of reported fields with the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_checker
    import sphc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire sphc_out_t m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // failed header reports all-zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_header |->
            !m_data.rope_mode && m_data.row_total == 8'd0
            && m_data.width_first == 17'd0 && m_data.width_second == 17'd0
            && m_data.width_third == 17'd0 && m_data.module_size == 64'd0)
        else $error("nonzero fields on failed header");

    // passed header has fields within limits
    a_pass_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_header |->
            m_data.row_total != 8'd0 && m_data.row_total <= 8'd128
            && m_data.width_first != 17'd0 && m_data.width_first[2:0] == 3'd0
            && m_data.width_second != 17'd0 && m_data.width_second[2:0] == 3'd0
            && m_data.width_third != 17'd0 && m_data.width_third[2:0] == 3'd0
            && m_data.module_size != 64'd0)
        else $error("passed header with field out of range");

    // rope mode has its fixed geometry
    a_rope_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_header && m_data.rope_mode |->
            m_data.row_total == ROPE_ROWS && m_data.width_first == ROPE_WIDTH_FIRST
            && m_data.width_second == ROPE_WIDTH_OTHER
            && m_data.width_third == ROPE_WIDTH_OTHER)
        else $error("rope header with wrong geometry");

endmodule

bind split_payload_header_checker sphc_checker u_sphc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
